@@ rtl/selcall_pkg.sv @@
// shared types, constants and the sine table for the selective-calling tone generator
// no dependencies; imported by every module of the block except selcall_ram
`timescale 1ns / 1ps

package selcall_pkg;

    // sizing
    localparam int QUEUE_DEPTH   = 64;
    localparam int QADDR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int TONE_SAMPLES  = 560;
    localparam int TONE_CNT_W    = 16;
    localparam int SINE_ENTRIES  = 256;
    localparam int SINE_IDX_W    = $clog2(SINE_ENTRIES);
    localparam int PHASE_W       = 32;
    localparam int CHAR_W        = 8;
    localparam int SAMPLE_W      = 13;
    localparam int TONE_IDX_W    = 5;
    localparam int NUM_TONE_REGS = 7;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;

    // word codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_OFFSET = 3'd7;

    // tone indexes
    localparam logic [TONE_IDX_W-1:0] TONE_END    = 5'd11;
    localparam logic [TONE_IDX_W-1:0] TONE_PAGER  = 5'd13;
    localparam logic [TONE_IDX_W-1:0] TONE_REPEAT = 5'd14;
    localparam logic [TONE_IDX_W-1:0] TONE_NONE   = 5'd16;

    // characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_D_UPPER = 8'h44;
    localparam logic [CHAR_W-1:0] CHAR_D_LOWER = 8'h64;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;

    localparam logic signed [SAMPLE_W-1:0] DAC_OFFSET = 13'sd2048;

    typedef logic [NUM_TONE_REGS-1:0][CFG_DATA_W-1:0] tone_regs_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    // round(2000*sin(2*pi*k/256)) for the first quarter wave, k = 0..64
    localparam logic [10:0] QUARTER_SINE [0:64] = '{
        11'd0,    11'd49,   11'd98,   11'd147,  11'd196,  11'd245,  11'd293,  11'd342,
        11'd390,  11'd438,  11'd486,  11'd533,  11'd581,  11'd627,  11'd674,  11'd720,
        11'd765,  11'd810,  11'd855,  11'd899,  11'd943,  11'd986,  11'd1028, 11'd1070,
        11'd1111, 11'd1152, 11'd1191, 11'd1230, 11'd1269, 11'd1306, 11'd1343, 11'd1379,
        11'd1414, 11'd1448, 11'd1482, 11'd1514, 11'd1546, 11'd1577, 11'd1606, 11'd1635,
        11'd1663, 11'd1690, 11'd1715, 11'd1740, 11'd1764, 11'd1786, 11'd1808, 11'd1828,
        11'd1848, 11'd1866, 11'd1883, 11'd1899, 11'd1914, 11'd1928, 11'd1940, 11'd1951,
        11'd1962, 11'd1971, 11'd1978, 11'd1985, 11'd1990, 11'd1995, 11'd1998, 11'd1999,
        11'd2000
    };

    // full-wave sine from the quarter table by folding
    function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
        input logic [SINE_IDX_W-1:0] k
    );
        logic [6:0]  q;
        logic [6:0]  qf;
        logic [10:0] v;
        q  = k[6:0];
        qf = (q > 7'd64) ? 7'(8'd128 - {1'b0, q}) : q;
        v  = QUARTER_SINE[qf];
        return k[7] ? -$signed({2'b00, v}) : $signed({2'b00, v});
    endfunction

    // phase increment of a tone index
    function automatic logic [PHASE_W-1:0] tone_step(
        input logic [TONE_IDX_W-1:0] idx,
        input tone_regs_t            regs
    );
        logic [CFG_DATA_W-1:0] pair;
        logic [PHASE_W-1:0]    step;
        pair = regs[idx[3:1]];
        unique case (idx) inside
            [5'd0:5'd9]:  step = idx[0] ? pair[63:32] : pair[31:0];
            TONE_END:     step = regs[5][31:0];
            TONE_PAGER:   step = regs[5][63:32];
            TONE_REPEAT:  step = regs[6][31:0];
            default:      step = '0;
        endcase
        return step;
    endfunction

endpackage

@@ rtl/selcall_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module selcall_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/selcall_queue.sv @@
// character ring queue: pointers, fill count and a write-through bypass in front of the ram
// depends on selcall_pkg and selcall_ram
`timescale 1ns / 1ps

module selcall_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  selcall_pkg::queue_ctrl_t       ctrl,
    input  logic [selcall_pkg::CHAR_W-1:0] push_char,
    output selcall_pkg::queue_stat_t       stat,
    output logic [selcall_pkg::CHAR_W-1:0] head_char
);
    import selcall_pkg::*;

    logic [QADDR_W-1:0] head_reg, head_next;
    logic [QADDR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               bypass_reg;
    logic [CHAR_W-1:0]  bypass_data_reg;
    logic [CHAR_W-1:0]  ram_rdata;
    logic               do_push;
    logic               do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

    assign do_push = ctrl.push && !stat.full;
    assign do_pop  = ctrl.pop && !stat.empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_pop)
        begin
            head_next = (head_reg == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push)
        begin
            tail_next = (tail_reg == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // read address runs one step ahead so the front entry is ready every cycle
    selcall_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (tail_reg),
        .wdata (push_char),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            bypass_reg <= do_push && (tail_reg == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= push_char;
    end

    assign head_char = bypass_reg ? bypass_data_reg : ram_rdata;

endmodule

@@ rtl/selcall_dds.sv @@
// tone sequencer and phase accumulator: tone changes, repeat handling and sample forming
// depends on selcall_pkg
`timescale 1ns / 1ps

module selcall_dds (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   tick,
    input  selcall_pkg::tone_regs_t                tone_regs,
    input  logic                                   dac_offset_en,
    input  selcall_pkg::queue_stat_t               qstat,
    input  logic [selcall_pkg::CHAR_W-1:0]         head_char,
    output logic                                   pop,
    output logic signed [selcall_pkg::SAMPLE_W-1:0] sample_now,
    output logic                                   silent_now
);
    import selcall_pkg::*;

    logic [PHASE_W-1:0]    acc_reg, acc_next;
    logic [PHASE_W-1:0]    step_reg, step_next;
    logic [TONE_CNT_W-1:0] count_reg, count_next;
    logic [TONE_IDX_W-1:0] last_reg, last_next;
    logic                  change;
    logic [PHASE_W-1:0]    acc_base;
    logic [TONE_IDX_W-1:0] char_idx;
    logic [TONE_IDX_W-1:0] use_idx;
    logic signed [SAMPLE_W-1:0] sine_val;

    assign change = (count_reg >= TONE_CNT_W'(TONE_SAMPLES));
    assign pop    = tick && change && !qstat.empty;

    // character to tone index: D or d to the pager tone, others clamped to the digit range
    always_comb
    begin
        if (head_char == CHAR_D_UPPER || head_char == CHAR_D_LOWER)
        begin
            char_idx = TONE_PAGER;
        end
        else if (head_char < CHAR_ZERO)
        begin
            char_idx = '0;
        end
        else if (head_char > CHAR_NINE)
        begin
            char_idx = 5'd9;
        end
        else
        begin
            char_idx = {1'b0, head_char[3:0]};
        end
        use_idx = (char_idx == last_reg) ? TONE_REPEAT : char_idx;
    end

    always_comb
    begin
        acc_base  = acc_reg;
        step_next = step_reg;
        last_next = last_reg;
        if (change)
        begin
            if (qstat.empty)
            begin
                acc_base  = '0;
                step_next = '0;
            end
            else if (head_char == CHAR_NEWLINE)
            begin
                step_next = tone_step(TONE_END, tone_regs);
                last_next = TONE_NONE;
            end
            else
            begin
                step_next = tone_step(use_idx, tone_regs);
                last_next = use_idx;
            end
        end
        count_next = change ? '0 : count_reg + 1'b1;
        acc_next   = acc_base + step_next;
    end

    assign sine_val   = sine_lookup(acc_base[PHASE_W-1 -: SINE_IDX_W]);
    assign sample_now = dac_offset_en ? sine_val + DAC_OFFSET : sine_val;
    assign silent_now = (step_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            step_reg  <= '0;
            count_reg <= '0;
            last_reg  <= TONE_NONE;
        end
        else if (tick)
        begin
            acc_reg   <= acc_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

endmodule

@@ rtl/selcall_tone_sequence_generator.sv @@
// top level of the selective-calling tone sequence generator
// depends on selcall_pkg, selcall_queue and selcall_dds
`timescale 1ns / 1ps

// Sequential-tone (selcall) generator. Each input word is either an enqueue
// (opcode 0, char_code goes into a 64-entry character queue, dropped when the
// queue is full, no result word) or a sample tick (opcode 1, exactly one result
// word: a 13-bit signed sine sample and a silent flag). One word is taken every
// clock cycle unless a tick waits on a stalled result; a tick passes through the
// input register, and its sample is loaded into the result register. While a
// sample still waits for out_ready, the next word can enter the input register;
// an enqueue then passes on to the queue, a tick waits there. A tone lasts
// 561 ticks, after which the next queued character picks the next tone; an
// empty queue gives silence with the phase cleared. Newline plays the end tone,
// D or d the pager tone, any other character a digit tone, and a tone equal to
// the one before plays the repeat tone. The tone increments and the DAC offset
// enable are written through the cfg port, by the user only while the block is
// idle, not enforced by the block. The queue ram needs no clearing after reset.
module selcall_tone_sequence_generator (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration
    input  logic                                      cfg_we,
    input  logic [selcall_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [selcall_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input words
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      opcode,
    input  logic [selcall_pkg::CHAR_W-1:0]            char_code,
    // result words
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [selcall_pkg::SAMPLE_W-1:0]   sample,
    output logic                                      silent
);
    import selcall_pkg::*;

    // configuration registers
    tone_regs_t tone_regs_reg;
    logic       dac_en_reg;

    // input stage
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_op_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_adv;
    logic              in_fire;

    // result stage
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       silent_reg;

    // between the parts
    queue_ctrl_t                qctrl;
    queue_stat_t                qstat;
    logic [CHAR_W-1:0]          head_char;
    logic                       tick;
    logic                       pop;
    logic signed [SAMPLE_W-1:0] sample_now;
    logic                       silent_now;

    // config writes: index 7 sets the DAC offset enable, every other index a tone register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_regs_reg <= '0;
            dac_en_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DAC_OFFSET)
            begin
                dac_en_reg <= cfg_data[0];
            end
            else
            begin
                tone_regs_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // an enqueue always moves on; a tick only when the result register can take it
    assign s1_adv   = s1_valid_reg && (s1_op_reg == OP_ENQUEUE || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;
    assign tick     = s1_adv && (s1_op_reg == OP_TICK);

    assign s1_valid_next = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg   <= opcode;
            s1_char_reg <= char_code;
        end
    end

    // character queue
    assign qctrl.push = s1_adv && (s1_op_reg == OP_ENQUEUE);
    assign qctrl.pop  = pop;

    selcall_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (qctrl),
        .push_char (s1_char_reg),
        .stat      (qstat),
        .head_char (head_char)
    );

    // tone sequencing and sine lookup
    selcall_dds u_dds (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .tone_regs     (tone_regs_reg),
        .dac_offset_en (dac_en_reg),
        .qstat         (qstat),
        .head_char     (head_char),
        .pop           (pop),
        .sample_now    (sample_now),
        .silent_now    (silent_now)
    );

    // result register
    assign out_valid_next = tick ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            sample_reg <= sample_now;
            silent_reg <= silent_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign silent    = silent_reg;

endmodule

@@ rtl/selcall_checker.sv @@
// port-level checks for the selective-calling tone generator, bound to the top level
// depends on selcall_pkg
`timescale 1ns / 1ps

module selcall_checker (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      cfg_we,
    input logic [selcall_pkg::CFG_IDX_W-1:0]         cfg_index,
    input logic [selcall_pkg::CFG_DATA_W-1:0]        cfg_data,
    input logic                                      in_valid,
    input logic                                      in_ready,
    input logic                                      opcode,
    input logic [selcall_pkg::CHAR_W-1:0]            char_code,
    input logic                                      out_valid,
    input logic                                      out_ready,
    input logic signed [selcall_pkg::SAMPLE_W-1:0]   sample,
    input logic                                      silent
);
    import selcall_pkg::*;

    // a waiting sample holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(silent))
        else $error("result word changed while stalled");

    // input back-pressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    // samples stay within the table range plus offset
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample >= -13'sd2000) && (sample <= 13'sd4048))
        else $error("sample out of range");

    // with the output free and nothing ahead, a tick passes the input and result registers
    a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid && in_ready) && in_valid && in_ready && opcode == OP_TICK
        |=> ##1 out_valid)
        else $error("tick produced no sample");

endmodule

bind selcall_tone_sequence_generator selcall_checker u_selcall_checker (.*);
